FILE: hdl/serial_frame_builder_with_checksum_assert.svh
// Assertion macros for the frame builder.
`ifndef SERIAL_FRAME_BUILDER_WITH_CHECKSUM_ASSERT_SVH
`define SERIAL_FRAME_BUILDER_WITH_CHECKSUM_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SFB_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define SFB_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: hdl/sfb_pkg.sv
`default_nettype none

package sfb_pkg;

    localparam int FifoDepth = 4;

    localparam logic [7:0] HeadReset    = 8'h0A;
    localparam logic [7:0] TrailerReset = 8'hBB;
    localparam logic [7:0] CsumInvert   = 8'hFF;

    localparam logic CfgHead    = 1'b0;
    localparam logic CfgTrailer = 1'b1;

    typedef enum logic [2:0] {
        ElHead,
        ElLen,
        ElType,
        ElCode,
        ElData,
        ElCsum,
        ElTrail
    } elem_t;

    typedef struct packed {
        logic       first;
        logic       has_data;
        logic       closes;
        logic [7:0] len;
        logic [7:0] msg_type;
        logic [7:0] msg_code;
        logic [7:0] data;
        logic [7:0] csum;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

FILE: hdl/sfb_front.sv
`default_nettype none

module sfb_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic [7:0]        msg_type,
    input  wire logic [7:0]        msg_code,
    input  wire logic [7:0]        payload_len,
    input  wire sfb_pkg::fifo_stat_t stat,
    output logic                   push,
    output sfb_pkg::cmd_t          cmd
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    logic [7:0] sum_hdr;
    logic [7:0] sum_new;
    logic [7:0] left_new;
    logic       has_data;
    logic       closes;

    assign in_ready = !stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        sum_hdr  = msg_type + msg_code + payload_len;
        has_data = in_frame_reg || (payload_len != 8'd0);
        if (in_frame_reg)
        begin
            sum_new  = sum_reg + data_byte;
            left_new = bytes_left_reg - 8'd1;
        end
        else if (has_data)
        begin
            sum_new  = sum_hdr + data_byte;
            left_new = payload_len - 8'd1;
        end
        else
        begin
            sum_new  = sum_hdr;
            left_new = 8'd0;
        end
        closes = (left_new == 8'd0);

        cmd.first    = !in_frame_reg;
        cmd.has_data = has_data;
        cmd.closes   = closes;
        cmd.len      = payload_len;
        cmd.msg_type = msg_type;
        cmd.msg_code = msg_code;
        cmd.data     = data_byte;
        cmd.csum     = sum_new ^ sfb_pkg::CsumInvert;

        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        if (push)
        begin
            in_frame_next   = !closes;
            bytes_left_next = left_new;
            sum_next        = closes ? 8'd0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
            sum_reg        <= 8'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sfb_fifo.sv
`default_nettype none

module sfb_fifo
#(
    parameter int DEPTH = sfb_pkg::FifoDepth
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sfb_pkg::cmd_t       push_cmd,
    input  wire logic                pop,
    output sfb_pkg::cmd_t            head_cmd,
    output sfb_pkg::fifo_stat_t      stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    sfb_pkg::cmd_t   entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign stat.full  = (count_reg == FullCnt);
    assign stat.empty = (count_reg == '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sfb_back.sv
`default_nettype none

module sfb_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [7:0]          cfg_wdata,
    input  wire sfb_pkg::cmd_t       head_cmd,
    input  wire sfb_pkg::fifo_stat_t stat,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               out_byte,
    output logic                     frame_done,
    output logic                     run_last
);

    logic [7:0] head_val_reg;
    logic [7:0] trailer_val_reg;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       frame_done_reg;
    logic       run_last_reg;

    logic            load;
    logic [3:0]      elem_base;
    logic [3:0]      elem_idx;
    logic [3:0]      elem_cnt;
    logic            elem_last;
    sfb_pkg::elem_t  elem;
    logic [7:0]      cur_byte;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign frame_done = frame_done_reg;
    assign run_last   = run_last_reg;

    always_comb
    begin
        elem_base = {1'b0, pos_reg} + (head_cmd.first ? 4'd0 : 4'd4);
        elem_idx  = elem_base + {3'd0, (elem_base >= 4'd4) && !head_cmd.has_data};
        elem_cnt  = (head_cmd.first ? 4'd4 : 4'd0) + {3'd0, head_cmd.has_data}
                  + (head_cmd.closes ? 4'd2 : 4'd0);
        elem_last = ({1'b0, pos_reg} == (elem_cnt - 4'd1));
        elem      = sfb_pkg::elem_t'(elem_idx[2:0]);

        case (elem)
            sfb_pkg::ElHead:  cur_byte = head_val_reg;
            sfb_pkg::ElLen:   cur_byte = head_cmd.len;
            sfb_pkg::ElType:  cur_byte = head_cmd.msg_type;
            sfb_pkg::ElCode:  cur_byte = head_cmd.msg_code;
            sfb_pkg::ElData:  cur_byte = head_cmd.data;
            sfb_pkg::ElCsum:  cur_byte = head_cmd.csum;
            sfb_pkg::ElTrail: cur_byte = trailer_val_reg;
            default:          cur_byte = 8'd0;
        endcase

        load = !stat.empty && (!out_valid_reg || out_ready);
        pop  = load && elem_last;

        pos_next = pos_reg;
        if (load)
        begin
            pos_next = elem_last ? 3'd0 : pos_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // hold the result until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= cur_byte;
            frame_done_reg <= (elem == sfb_pkg::ElTrail);
            run_last_reg   <= elem_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_val_reg    <= sfb_pkg::HeadReset;
            trailer_val_reg <= sfb_pkg::TrailerReset;
            pos_reg         <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == sfb_pkg::CfgHead))
            begin
                head_val_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == sfb_pkg::CfgTrailer))
            begin
                trailer_val_reg <= cfg_wdata;
            end
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/serial_frame_builder_with_checksum.sv
// Serial frame builder: turns a stream of payload bytes into framed bytes
// (head, length, type, code, payload, inverted-sum checksum, trailer).
// Input channel in_valid/in_ready carries data_byte, msg_type, msg_code and
// payload_len; the first transaction of a frame supplies the header fields.
// Output channel out_valid/out_ready carries one frame byte per transaction,
// with frame_done on the trailer and run_last on the last byte of an input.
// Config port cfg_we/cfg_index/cfg_wdata sets head (0) and trailer (1) bytes.
// The first byte of an input passes through the queue entry and then the output register.
// Throughput: one output byte per cycle while out_ready is high, set by the single
// output register; a payload item is one byte, or three when it closes the frame,
// and a frame start is 5 to 7 bytes, so inputs flow at one per cycle mid-frame while
// out_ready is high, and are absorbed by a FIFO_DEPTH entry queue.
// When the receiver stalls, the output holds and the queue fills; in_ready
// drops only while the queue is full.
// Reset clears the frame state, the queue and out_valid, and loads the
// head and trailer registers with 0x0A and 0xBB.
`default_nettype none

module serial_frame_builder_with_checksum
#(
    parameter int FIFO_DEPTH = sfb_pkg::FifoDepth
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] msg_type,
    input  wire logic [7:0] msg_code,
    input  wire logic [7:0] payload_len,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            frame_done,
    output logic            run_last,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    `include "serial_frame_builder_with_checksum_assert.svh"

    logic                push;
    logic                pop;
    sfb_pkg::cmd_t       push_cmd;
    sfb_pkg::cmd_t       head_cmd;
    sfb_pkg::fifo_stat_t stat;

    sfb_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .msg_type    (msg_type),
        .msg_code    (msg_code),
        .payload_len (payload_len),
        .stat        (stat),
        .push        (push),
        .cmd         (push_cmd)
    );

    sfb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (stat)
    );

    sfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .head_cmd   (head_cmd),
        .stat       (stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .frame_done (frame_done),
        .run_last   (run_last)
    );

    `SFB_ASSERT_NOW(a_done_ends_run, clk, rst_n, out_valid && frame_done, run_last, "bad trailer")
    `SFB_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !stat.full, "queue overflow")
    `SFB_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !stat.empty, "queue underflow")
    `SFB_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, out_valid && run_last, "pop not last")

endmodule

`default_nettype wire
